// ----- rtl/page_framebuffer_rect_fill_macros.svh -----
// Assertion macros for the page frame buffer block.
// No dependencies; included by files that carry concurrent checks.
`ifndef PAGE_FRAMEBUFFER_RECT_FILL_MACROS_SVH
`define PAGE_FRAMEBUFFER_RECT_FILL_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define PFB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfb check failed");
// next-cycle implication
`define PFB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfb check failed");
`else
`define PFB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PFB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/pfb_pkg.sv -----
// Shared types, constants and the page mask function of the frame buffer.
// No dependencies.
package pfb_pkg;

  localparam int COORD_W   = 8;
  localparam int IDX_W     = 9;
  localparam int DATA_W    = 8;
  localparam int PAGE_BITS = 3;
  localparam int PAGE_W    = COORD_W - PAGE_BITS;
  localparam logic [DATA_W-1:0] BYTE_ZERO = 8'h00;

  typedef enum logic [1:0] {
    ACT_FILL  = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_FILL,
    ST_DRAIN,
    ST_READ,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic start_fill;
    logic start_lin;
    logic step;
  } walk_ctrl_t;

  typedef struct packed {
    logic empty;   // clipped region holds no pixel
    logic clip;    // rectangle reaches off the panel
    logic last;    // current byte is the final one of the walk
  } walk_stat_t;

  // Bits lo..hi of one page byte set.
  function automatic logic [DATA_W-1:0] page_mask(input logic [PAGE_BITS-1:0] lo,
                                                  input logic [PAGE_BITS-1:0] hi);
    logic [DATA_W-1:0] m;
    m = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
    return m;
  endfunction

endpackage

// ----- rtl/pfb_if.sv -----
// Valid/ready channel interfaces for items into and results out of the block.
// Depends on pfb_pkg.
interface pfb_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic [pfb_pkg::COORD_W-1:0]   x_start;
  logic [pfb_pkg::COORD_W-1:0]   x_end;
  logic [pfb_pkg::COORD_W-1:0]   y_start;
  logic [pfb_pkg::COORD_W-1:0]   y_end;
  logic [pfb_pkg::IDX_W-1:0]     read_index;

  modport source (output valid, action, x_start, x_end, y_start, y_end, read_index,
                  input ready);
  modport sink   (input valid, action, x_start, x_end, y_start, y_end, read_index,
                  output ready);
endinterface

interface pfb_out_if;
  logic                        valid;
  logic                        ready;
  logic [pfb_pkg::DATA_W-1:0]  read_data;
  logic                        clipped;

  modport source (output valid, read_data, clipped, input ready);
  modport sink   (input valid, read_data, clipped, output ready);
endinterface

// ----- rtl/pfb_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/pfb_walker.sv -----
// Address and mask sequencer: walks the bytes of a clipped rectangle page by
// page, or every byte of the store in order. Depends on pfb_pkg.
module pfb_walker #(
  parameter int COLUMNS      = 128,
  parameter int BUFFER_BYTES = 512
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pfb_pkg::walk_ctrl_t                 ctrl_i,
  input  logic [pfb_pkg::COORD_W-1:0]         x_start_i,
  input  logic [pfb_pkg::COORD_W-1:0]         x_end_i,
  input  logic [pfb_pkg::COORD_W-1:0]         y_start_i,
  input  logic [pfb_pkg::COORD_W-1:0]         y_end_i,
  output logic [$clog2(BUFFER_BYTES)-1:0]     addr_o,
  output logic [pfb_pkg::DATA_W-1:0]          mask_o,
  output pfb_pkg::walk_stat_t                 stat_o
);
  import pfb_pkg::*;

  localparam int AW         = $clog2(BUFFER_BYTES);
  localparam int BW         = AW + 1;
  localparam int XW         = COORD_W + 1;
  localparam int YW         = 12;
  localparam int PANEL_ROWS = (BUFFER_BYTES / COLUMNS) * 8;
  localparam logic [XW-1:0] COL_LIM  = XW'(COLUMNS);
  localparam logic [YW-1:0] ROW_LIM  = YW'(PANEL_ROWS);
  localparam logic [AW-1:0] LIN_LAST = AW'(BUFFER_BYTES - 1);
  localparam logic [BW-1:0] BASE_INC = BW'(COLUMNS);

  logic [XW-1:0]        x0_w, x1_w, xe;
  logic [YW-1:0]        y0_w, y1_w, ye, ye_m1;
  logic                 raw_empty;

  logic                 lin_mode_q, lin_mode_d;
  logic [AW-1:0]        lin_q, lin_d;
  logic [COORD_W-1:0]   col_q, col_d, col_first_q, col_first_d, col_last_q, col_last_d;
  logic [PAGE_W-1:0]    page_q, page_d, page_first_q, page_first_d, page_last_q, page_last_d;
  logic [PAGE_BITS-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [BW-1:0]        base_q, base_d;
  logic                 col_end;

  // Clip the rectangle to the panel.
  always_comb begin
    x0_w      = {1'b0, x_start_i};
    x1_w      = {1'b0, x_end_i};
    y0_w      = {4'b0, y_start_i};
    y1_w      = {4'b0, y_end_i};
    xe        = (x1_w > COL_LIM) ? COL_LIM : x1_w;
    ye        = (y1_w > ROW_LIM) ? ROW_LIM : y1_w;
    ye_m1     = ye - 12'd1;
    raw_empty = (x_start_i >= x_end_i) || (y_start_i >= y_end_i);
  end

  assign col_end = (col_q == col_last_q);

  always_comb begin
    lin_mode_d   = lin_mode_q;
    lin_d        = lin_q;
    col_d        = col_q;
    col_first_d  = col_first_q;
    col_last_d   = col_last_q;
    page_d       = page_q;
    page_first_d = page_first_q;
    page_last_d  = page_last_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    base_d       = base_q;
    if (ctrl_i.start_lin) begin
      lin_mode_d = 1'b1;
      lin_d      = '0;
    end else if (ctrl_i.start_fill) begin
      lin_mode_d   = 1'b0;
      col_d        = x_start_i;
      col_first_d  = x_start_i;
      col_last_d   = COORD_W'(xe - 9'd1);
      page_d       = y_start_i[COORD_W-1:PAGE_BITS];
      page_first_d = y_start_i[COORD_W-1:PAGE_BITS];
      page_last_d  = ye_m1[COORD_W-1:PAGE_BITS];
      lo_d         = y_start_i[PAGE_BITS-1:0];
      hi_d         = ye_m1[PAGE_BITS-1:0];
      base_d       = BW'(int'(y_start_i[COORD_W-1:PAGE_BITS]) * COLUMNS);
    end else if (ctrl_i.step) begin
      if (lin_mode_q) begin
        lin_d = lin_q + AW'(1);
      end else if (col_end) begin
        col_d  = col_first_q;
        page_d = page_q + PAGE_W'(1);
        base_d = base_q + BASE_INC;
      end else begin
        col_d = col_q + COORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lin_mode_q <= 1'b1;
      lin_q      <= '0;
    end else begin
      lin_mode_q <= lin_mode_d;
      lin_q      <= lin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q        <= col_d;
    col_first_q  <= col_first_d;
    col_last_q   <= col_last_d;
    page_q       <= page_d;
    page_first_q <= page_first_d;
    page_last_q  <= page_last_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    base_q       <= base_d;
  end

  always_comb begin
    addr_o = lin_mode_q ? lin_q : AW'(base_q + BW'(col_q));
    mask_o = page_mask((page_q == page_first_q) ? lo_q : 3'd0,
                       (page_q == page_last_q)  ? hi_q : 3'd7);
    stat_o.empty = (x0_w >= xe) || (y0_w >= ye);
    stat_o.clip  = !raw_empty && ((x1_w > COL_LIM) || (y1_w > ROW_LIM));
    stat_o.last  = lin_mode_q ? (lin_q == LIN_LAST)
                              : (col_end && (page_q == page_last_q));
  end

endmodule

// ----- rtl/page_framebuffer_rect_fill.sv -----
// Top level of the page-layout monochrome frame buffer with rectangle fill.
// Depends on pfb_pkg, pfb_if, pfb_ram, pfb_walker and the assertion macros.
`include "page_framebuffer_rect_fill_macros.svh"

// One item at a time. The store is a single RAM with one read-modify-write
// per cycle, and that port sets all timings. After reset a clearing pass
// over every byte of the store runs with in_i.ready low. A fill walks the
// covered bytes of the clipped rectangle page by page and goes straight to
// the result when that rectangle is empty; a clear writes zero to every
// byte; a read past the store or an unused action code goes straight to
// the result. A new item is taken while the previous result still sits
// in the output register.
module page_framebuffer_rect_fill #(
  parameter int COLUMNS      = 128,
  parameter int BUFFER_BYTES = 512
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pfb_in_if.sink        in_i,
  pfb_out_if.source     out_o
);
  import pfb_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam logic [11:0] BUF_LIM = 12'(BUFFER_BYTES);

  state_e            state_q, state_d;
  logic              item_q, item_d;
  logic [DATA_W-1:0] res_data_q, res_data_d;
  logic              res_clip_q, res_clip_d;
  logic              rmw_vld_q, rmw_vld_d;
  logic [AW-1:0]     rmw_addr_q;
  logic [DATA_W-1:0] rmw_mask_q;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q;
  logic              out_clip_q;
  logic              out_load;

  walk_ctrl_t        walk_ctrl;
  walk_stat_t        walk_stat;
  logic [AW-1:0]     walk_addr;
  logic [DATA_W-1:0] walk_mask;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  logic              accept;
  action_e           act;
  logic              read_ok;

  pfb_walker #(
    .COLUMNS      (COLUMNS),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (walk_ctrl),
    .x_start_i (in_i.x_start),
    .x_end_i   (in_i.x_end),
    .y_start_i (in_i.y_start),
    .y_end_i   (in_i.y_end),
    .addr_o    (walk_addr),
    .mask_o    (walk_mask),
    .stat_o    (walk_stat)
  );

  pfb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (BUFFER_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign act        = action_e'(in_i.action);
  assign read_ok    = ({3'b0, in_i.read_index} < BUF_LIM);

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    res_data_d = res_data_q;
    res_clip_d = res_clip_q;
    rmw_vld_d  = 1'b0;
    walk_ctrl  = '0;
    ram_re     = 1'b0;
    ram_raddr  = walk_addr;
    ram_we     = rmw_vld_q;
    ram_waddr  = rmw_addr_q;
    ram_wdata  = ram_rdata | rmw_mask_q;   // merge fill bits into stored byte
    out_load   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          item_d     = 1'b1;
          res_data_d = BYTE_ZERO;
          res_clip_d = 1'b0;
          case (act)
            ACT_FILL: begin
              res_clip_d = walk_stat.clip;
              if (walk_stat.empty) begin
                state_d = ST_RESULT;
              end else begin
                walk_ctrl.start_fill = 1'b1;
                state_d              = ST_FILL;
              end
            end
            ACT_CLEAR: begin
              walk_ctrl.start_lin = 1'b1;
              state_d             = ST_CLEAR;
            end
            ACT_READ: begin
              if (read_ok) begin
                ram_re    = 1'b1;
                ram_raddr = AW'(in_i.read_index);
                state_d   = ST_READ;
              end else begin
                state_d = ST_RESULT;
              end
            end
            default: begin
              state_d = ST_RESULT;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        ram_we         = 1'b1;
        ram_waddr      = walk_addr;
        ram_wdata      = BYTE_ZERO;
        walk_ctrl.step = 1'b1;
        if (walk_stat.last) begin
          state_d = item_q ? ST_RESULT : ST_IDLE;
        end
      end
      ST_FILL: begin
        ram_re         = 1'b1;
        rmw_vld_d      = 1'b1;
        walk_ctrl.step = 1'b1;
        if (walk_stat.last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_RESULT;
      end
      ST_READ: begin
        res_data_d = ram_rdata;
        state_d    = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          item_d   = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;   // clearing pass over the store after reset
      item_q      <= 1'b0;
      rmw_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      item_q      <= item_d;
      rmw_vld_q   <= rmw_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_data_q <= res_data_d;
    res_clip_q <= res_clip_d;
    rmw_addr_q <= walk_addr;
    rmw_mask_q <= walk_mask;
    if (out_load) begin
      out_data_q <= res_data_q;
      out_clip_q <= res_clip_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = out_data_q;
  assign out_o.clipped   = out_clip_q;

  `PFB_ASSERT_IMP(a_no_rw_collide, clk_i, rst_ni, ram_we && ram_re, ram_waddr != ram_raddr)
  `PFB_ASSERT_IMP(a_no_rmw_on_accept, clk_i, rst_ni, accept, !rmw_vld_q)
  `PFB_ASSERT_NXT(a_fill_drains, clk_i, rst_ni, (state_q == ST_FILL) && walk_stat.last, (state_q == ST_DRAIN) && rmw_vld_q)
  `PFB_ASSERT_IMP(a_out_no_overwrite, clk_i, rst_ni, out_load, !out_valid_q || out_o.ready)

endmodule
